FILE: rtl/core/text_token_boundary_scanner_assert.svh
// Assertion macros used by the scanner's checker.
`ifndef TEXT_TOKEN_BOUNDARY_SCANNER_ASSERT_SVH
`define TEXT_TOKEN_BOUNDARY_SCANNER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tts_pkg.sv
// Shared types, constants and helpers of the token boundary scanner.
package tts_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int FIELD_W     = 16;
  localparam int SAT_W       = (OFFSET_BITS + 1 > FIELD_W) ? OFFSET_BITS + 1 : FIELD_W;

  localparam logic [FIELD_W-1:0]     FIELD_MAX  = '1;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
  localparam logic [OFFSET_BITS:0]   LEN_ZERO   = '0;
  localparam logic [OFFSET_BITS:0]   LEN_ONE    = (OFFSET_BITS + 1)'(1);

  // Up to three tokens per item; count fits in two bits.
  localparam int MAX_RESULTS = 3;
  localparam int COUNT_W     = 2;

  // Result queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  typedef enum logic [2:0] {
    KIND_WORD    = 3'd0,
    KIND_NUMBER  = 3'd1,
    KIND_STRING  = 3'd2,
    KIND_NEWLINE = 3'd3,
    KIND_SINGLE  = 3'd4,
    KIND_END     = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_WORD,
    MODE_INT,
    MODE_DOT,
    MODE_FRAC,
    MODE_STRING
  } mode_t;

  typedef struct packed {
    kind_t              kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] length;
    logic               last;
  } token_t;

  typedef struct packed {
    mode_t                  mode;
    logic [OFFSET_BITS-1:0] tok_begin;
    logic [OFFSET_BITS-1:0] pos;
    logic                   finished;
  } scan_state_t;

  // Clamp a wide offset or length to the result field.
  function automatic logic [FIELD_W-1:0] sat_field(logic [OFFSET_BITS:0] v);
    logic [SAT_W-1:0] w;
    w = SAT_W'(v);
    if (w > SAT_W'(FIELD_MAX)) begin
      return FIELD_MAX;
    end
    return w[FIELD_W-1:0];
  endfunction

  // Distance from a to b, never below zero.
  function automatic logic [OFFSET_BITS:0] span(logic [OFFSET_BITS-1:0] a,
                                                logic [OFFSET_BITS-1:0] b);
    return (b > a) ? (OFFSET_BITS + 1)'(b - a) : LEN_ZERO;
  endfunction

  function automatic token_t make_tok(kind_t k, logic [OFFSET_BITS-1:0] start,
                                      logic [OFFSET_BITS:0] len);
    token_t t;
    t.kind   = k;
    t.start  = sat_field({1'b0, start});
    t.length = sat_field(len);
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

FILE: rtl/core/tts_scan.sv
// Combinational scan step: tokens and next state for one held item.
module tts_scan (
  input  tts_pkg::scan_state_t                       st,
  input  logic [7:0]                                 char_byte,
  input  logic                                       end_of_text,
  output tts_pkg::scan_state_t                       nx,
  output tts_pkg::token_t [tts_pkg::MAX_RESULTS-1:0] toks,
  output logic [tts_pkg::COUNT_W-1:0]                tok_count
);
  import tts_pkg::*;

  logic [OFFSET_BITS-1:0] p;
  logic [OFFSET_BITS-1:0] dot_m1;
  logic [OFFSET_BITS-1:0] dot_ofs;
  logic [OFFSET_BITS:0]   span_bp;
  logic [OFFSET_BITS:0]   span_bd;
  logic is_ws, is_nl, is_slash, is_quote, is_dot, is_digit, is_alpha, is_wordc;
  logic ti_emit, ti_begin;
  mode_t  ti_mode;
  token_t ti_tok;

  assign p = st.pos;

  // Byte classes
  assign is_ws    = (char_byte == CH_SPACE) || (char_byte == CH_TAB) || (char_byte == CH_CR);
  assign is_nl    = (char_byte == CH_NL);
  assign is_slash = (char_byte == CH_SLASH);
  assign is_quote = (char_byte == CH_QUOTE);
  assign is_dot   = (char_byte == CH_DOT);
  assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign is_alpha = ((char_byte >= CH_LO_A) && (char_byte <= CH_LO_Z)) ||
                    ((char_byte >= CH_UP_A) && (char_byte <= CH_UP_Z)) ||
                    (char_byte == CH_UNDER) || (char_byte == CH_DASH);
  assign is_wordc = is_alpha || is_digit;

  // Byte taken between tokens
  assign ti_emit  = !is_ws && (is_nl || !(is_slash || is_quote || is_alpha || is_digit));
  assign ti_begin = !is_ws && !is_nl;
  assign ti_tok   = make_tok(is_nl ? KIND_NEWLINE : KIND_SINGLE, p, LEN_ONE);
  assign ti_mode  = is_slash ? MODE_SLASH  :
                    is_quote ? MODE_STRING :
                    is_alpha ? MODE_WORD   :
                    is_digit ? MODE_INT    : MODE_IDLE;

  // Held dot sits one byte back, never before the number start
  assign dot_m1  = (p != '0) ? p - 1'b1 : '0;
  assign dot_ofs = (dot_m1 < st.tok_begin) ? st.tok_begin : dot_m1;
  assign span_bp = span(st.tok_begin, p);
  assign span_bd = span(st.tok_begin, dot_ofs);

  // Next state
  always_comb begin
    logic idle_go;
    idle_go = 1'b0;
    nx      = st;
    if (!st.finished) begin
      if (end_of_text) begin
        nx.mode     = MODE_IDLE;
        nx.finished = 1'b1;
      end else begin
        if (p != OFFSET_MAX) begin
          nx.pos = p + 1'b1;
        end
        unique case (st.mode)
          MODE_SLASH: begin
            if (is_slash) nx.mode = MODE_COMMENT;
            else idle_go = 1'b1;
          end
          MODE_COMMENT: idle_go = is_nl;
          MODE_WORD:    idle_go = !is_wordc;
          MODE_INT: begin
            if (is_dot) nx.mode = MODE_DOT;
            else idle_go = !is_digit;
          end
          MODE_DOT: begin
            if (is_digit) nx.mode = MODE_FRAC;
            else idle_go = 1'b1;
          end
          MODE_FRAC: idle_go = !is_digit;
          MODE_STRING: begin
            if (is_quote) nx.mode = MODE_IDLE;
          end
          default: idle_go = 1'b1;
        endcase
        if (idle_go) begin
          nx.mode = ti_mode;
          if (ti_begin) nx.tok_begin = p;
        end
      end
    end
  end

  // Tokens
  always_comb begin
    logic [COUNT_W-1:0] n;
    token_t [MAX_RESULTS-1:0] tk;
    logic idle_go;
    n       = '0;
    tk      = '0;
    idle_go = 1'b0;
    if (st.finished) begin
      tk[0] = make_tok(KIND_END, p, LEN_ZERO);
      n     = COUNT_W'(1);
    end else if (end_of_text) begin
      unique case (st.mode)
        MODE_SLASH: begin
          tk[0] = make_tok(KIND_SINGLE, st.tok_begin, LEN_ONE);
          tk[1] = make_tok(KIND_END, p, LEN_ZERO);
          n     = COUNT_W'(2);
        end
        MODE_WORD: begin
          tk[0] = make_tok(KIND_WORD, st.tok_begin, span_bp);
          tk[1] = make_tok(KIND_END, p, LEN_ZERO);
          n     = COUNT_W'(2);
        end
        MODE_INT, MODE_FRAC: begin
          tk[0] = make_tok(KIND_NUMBER, st.tok_begin, span_bp);
          tk[1] = make_tok(KIND_END, p, LEN_ZERO);
          n     = COUNT_W'(2);
        end
        MODE_DOT: begin
          tk[0] = make_tok(KIND_NUMBER, st.tok_begin, span_bd);
          tk[1] = make_tok(KIND_SINGLE, dot_ofs, LEN_ONE);
          tk[2] = make_tok(KIND_END, p, LEN_ZERO);
          n     = COUNT_W'(3);
        end
        MODE_STRING: begin
          tk[0] = make_tok(KIND_END, st.tok_begin, span_bp);
          n     = COUNT_W'(1);
        end
        default: begin
          tk[0] = make_tok(KIND_END, p, LEN_ZERO);
          n     = COUNT_W'(1);
        end
      endcase
    end else begin
      unique case (st.mode)
        MODE_SLASH: begin
          if (!is_slash) begin
            tk[0]   = make_tok(KIND_SINGLE, st.tok_begin, LEN_ONE);
            n       = COUNT_W'(1);
            idle_go = 1'b1;
          end
        end
        MODE_COMMENT: idle_go = is_nl;
        MODE_WORD: begin
          if (!is_wordc) begin
            tk[0]   = make_tok(KIND_WORD, st.tok_begin, span_bp);
            n       = COUNT_W'(1);
            idle_go = 1'b1;
          end
        end
        MODE_INT: begin
          if (!is_dot && !is_digit) begin
            tk[0]   = make_tok(KIND_NUMBER, st.tok_begin, span_bp);
            n       = COUNT_W'(1);
            idle_go = 1'b1;
          end
        end
        MODE_DOT: begin
          if (!is_digit) begin
            tk[0]   = make_tok(KIND_NUMBER, st.tok_begin, span_bd);
            tk[1]   = make_tok(KIND_SINGLE, dot_ofs, LEN_ONE);
            n       = COUNT_W'(2);
            idle_go = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (!is_digit) begin
            tk[0]   = make_tok(KIND_NUMBER, st.tok_begin, span_bp);
            n       = COUNT_W'(1);
            idle_go = 1'b1;
          end
        end
        MODE_STRING: begin
          if (is_quote) begin
            tk[0] = make_tok(KIND_STRING, st.tok_begin, span_bp + LEN_ONE);
            n     = COUNT_W'(1);
          end
        end
        default: idle_go = 1'b1;
      endcase
      if (idle_go && ti_emit) begin
        tk[n] = ti_tok;
        n     = n + 1'b1;
      end
    end
    for (int i = 0; i < MAX_RESULTS; i++) begin
      tk[i].last = (n != '0) && (COUNT_W'(i) == n - 1'b1);
    end
    toks      = tk;
    tok_count = n;
  end

endmodule

FILE: rtl/core/tts_result_queue.sv
// Small result queue: takes up to three tokens a cycle, drains one.
module tts_result_queue (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic [tts_pkg::COUNT_W-1:0]                push_count,
  input  tts_pkg::token_t [tts_pkg::MAX_RESULTS-1:0] push_tok,
  input  logic                                       pop,
  output tts_pkg::token_t                            head,
  output logic                                       not_empty,
  output logic                                       room
);
  import tts_pkg::*;

  token_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QCNT_W-1:0]   count_next;

  assign head       = entries[rd_ptr];
  assign not_empty  = (count != '0);
  assign room       = (count <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS));
  assign count_next = count + QCNT_W'(push_count) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      wr_ptr <= wr_ptr + QPTR_W'(push_count);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (COUNT_W'(i) < push_count) begin
        entries[QPTR_W'(wr_ptr + QPTR_W'(i))] <= push_tok[i];
      end
    end
  end

endmodule

FILE: rtl/core/text_token_boundary_scanner.sv
// Token boundary scanner: takes a text one byte per item and reports each token's kind,
// start offset and length. Spaces, tabs, carriage returns and // comments are skipped; a
// newline is its own token; words, numbers (with an optional fraction that needs one byte
// of lookahead), quoted strings and one-byte tokens are reported on the item that shows
// where they end, so one item gives zero to three result items, the last flagged by
// last_of_run. An end_of_text item flushes any pending token and gives an end token of
// length 0 (an unterminated string instead gives one end token covering it); every item
// after that gives one more end token. Offsets and lengths saturate at 65535.
// Rate: one byte item per cycle while items give at most one result each and the output
// is not stalled. An item is held in the input register until the queue has room, then
// scanned and its results written into a four-entry result queue, from which they are
// offered in order. The single output port drains one result per cycle while token_ready
// is high, and the input stalls while the queue has fewer than three free entries.
module text_token_boundary_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_ready,
  input  logic [7:0]  char_byte,
  input  logic        end_of_text,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [2:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic        last_of_run
);
  import tts_pkg::*;

  // Input register
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_eot;

  // Scanner state and the step's outputs
  scan_state_t              st;
  scan_state_t              st_next;
  token_t [MAX_RESULTS-1:0] step_toks;
  logic [COUNT_W-1:0]       step_count;

  logic   advance;
  logic   queue_room;
  token_t head;

  // Advance the held item only when the queue can take its worst case of three results.
  assign advance    = hold_valid && queue_room;
  assign char_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      st         <= '{mode: MODE_IDLE, tok_begin: '0, pos: '0, finished: 1'b0};
    end else begin
      if (char_ready) begin
        hold_valid <= char_valid;
      end
      if (advance) begin
        st <= st_next;
      end
    end
  end

  // Payload needs no reset; load it on every accepted item.
  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      hold_byte <= char_byte;
      hold_eot  <= end_of_text;
    end
  end

  tts_scan u_scan (
    .st          (st),
    .char_byte   (hold_byte),
    .end_of_text (hold_eot),
    .nx          (st_next),
    .toks        (step_toks),
    .tok_count   (step_count)
  );

  tts_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (advance ? step_count : COUNT_W'(0)),
    .push_tok   (step_toks),
    .pop        (token_valid && token_ready),
    .head       (head),
    .not_empty  (token_valid),
    .room       (queue_room)
  );

  // Drive the result fields straight from the queue head register.
  assign token_kind   = 3'(head.kind);
  assign token_start  = head.start;
  assign token_length = head.length;
  assign last_of_run  = head.last;

endmodule

FILE: rtl/core/tts_checker.sv
// Port-level checker for the token boundary scanner, bound to the top level.
`include "text_token_boundary_scanner_assert.svh"

module tts_checker (
  input logic        clk,
  input logic        rst,
  input logic        token_valid,
  input logic        token_ready,
  input logic [2:0]  token_kind,
  input logic [15:0] token_start,
  input logic [15:0] token_length,
  input logic        last_of_run
);
  import tts_pkg::*;

  // Hold a stalled result in place.
  `TTS_ASSERT_NEXT(a_out_hold_valid, token_valid && !token_ready, token_valid, "result dropped while stalled")
  `TTS_ASSERT_NEXT(a_out_hold_data, token_valid && !token_ready, $stable(token_kind) && $stable(token_start) && $stable(token_length) && $stable(last_of_run), "stalled result changed")

  // Kinds stay within the defined codes.
  `TTS_ASSERT_IMPL(a_kind_range, token_valid, token_kind <= KIND_END, "undefined token kind")

  // A newline token is one byte and always closes its run.
  `TTS_ASSERT_IMPL(a_newline_shape, token_valid && token_kind == KIND_NEWLINE, token_length == 16'd1 && last_of_run, "malformed newline token")

endmodule

bind text_token_boundary_scanner tts_checker u_tts_checker (.*);
